/* rtl/cifa_pkg.sv */
// Package: shared types, operation and status codes for the checked fold ALU.
package cifa_pkg;

  localparam int DataWidth = 32;
  localparam int GroupPair = 2;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_MOD = 4'd4,
    OP_POW = 4'd5, OP_AND = 4'd6, OP_OR = 4'd7, OP_NOT = 4'd8, OP_GT = 4'd9,
    OP_GEQ = 4'd10, OP_LT = 4'd11, OP_LEQ = 4'd12
  } op_t;

  localparam logic [3:0] OpLastValid = 4'd12;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_OVF    = 3'd1;
  localparam logic [2:0] ST_DIVZ   = 3'd2;
  localparam logic [2:0] ST_NEGEXP = 3'd3;
  localparam logic [2:0] ST_COUNT  = 3'd4;

  // Controller to datapath.
  typedef struct packed {
    logic open;      // latch first operand, start a group
    logic fold;      // start folding the held operand into the accumulator
    logic finish;    // register the group result word
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic busy;      // multi-cycle step in flight
  } stat_t;

endpackage

/* rtl/cifa_if.sv */
// Interfaces: valid/ready channels for operand and result words.
interface cifa_in_if #(parameter int DATA_WIDTH = cifa_pkg::DataWidth);
  logic                         valid;
  logic                         ready;
  logic [3:0]                   command;
  logic signed [DATA_WIDTH-1:0] operand;
  logic                         last_operand;
  modport source (output valid, command, operand, last_operand, input ready);
  modport sink (input valid, command, operand, last_operand, output ready);
endinterface

interface cifa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [2:0]         status;
  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

/* rtl/cifa_datapath.sv */
// Datapath: accumulator, error tracking, iterative multiply, divide and power.
module cifa_datapath #(
  parameter int DATA_WIDTH = cifa_pkg::DataWidth
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cifa_pkg::cmd_t        cmd,
  input  logic [3:0]            command,
  input  logic [DATA_WIDTH-1:0] operand,
  output cifa_pkg::stat_t       stat,
  output logic [31:0]           value,
  output logic [2:0]            status
);
  localparam int W = DATA_WIDTH;
  localparam int CW = $clog2(W + 1);
  localparam logic [W-1:0] SignBit = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};

  typedef enum logic [2:0] {
    U_IDLE, U_MUL, U_DIV, U_POW_M, U_POW_S
  } unit_t;

  logic [W-1:0] acc, prev;
  logic [3:0]   op;
  logic [1:0]   cnt;
  logic         rel;
  logic [2:0]   err;
  unit_t        unit;

  // Shared shift-add multiplier over magnitudes.
  logic [W-1:0] ma, mb, mlim;
  logic [W:0]   mprod;
  logic         mneg, movf;
  // Restoring divider.
  logic [W-1:0] dq, dr, dd;
  logic         dnegq, dnegr;
  logic [CW-1:0] dcnt;
  // Power state.
  logic [W-1:0] pacc, psq, pe;
  logic         pmul_sel;   // 1: multiply acc*sq, 0: sq*sq

  function automatic logic [W-1:0] magf(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic slt(input logic [W-1:0] a, input logic [W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // Multiplier start values {ma, mb, mlim, mneg}; limit depends on the product sign.
  function automatic logic [3*W:0] mul_start(input logic [W-1:0] a, input logic [W-1:0] b);
    logic neg;
    neg = a[W-1] ^ b[W-1];
    return {magf(a), magf(b), neg ? SignBit : MaxPos, neg};
  endfunction

  logic [W:0]   madd;
  logic [W-1:0] add_r, sub_r, mres;
  logic         add_ovf, sub_ovf, relok;
  logic [W:0]   drem_sh, dsub;
  logic         dge;

  logic [W-1:0] ma_n, mb_n;
  logic [W:0]   mprod_n;
  logic         movf_n, mdone;

  always_comb begin
    add_r = acc + operand;
    sub_r = acc - operand;
    add_ovf = (acc[W-1] == operand[W-1]) && (add_r[W-1] != acc[W-1]);
    sub_ovf = (acc[W-1] != operand[W-1]) && (sub_r[W-1] != acc[W-1]);
    unique case (op)
      cifa_pkg::OP_GT:  relok = slt(operand, prev);
      cifa_pkg::OP_GEQ: relok = !slt(prev, operand);
      cifa_pkg::OP_LT:  relok = slt(prev, operand);
      default:          relok = !slt(operand, prev);
    endcase
    // Remainder with the next dividend bit shifted in.
    drem_sh = {dr, dq[W-1]};
    dsub = drem_sh - {1'b0, dd};
    dge = (drem_sh >= {1'b0, dd});
  end

  // One multiplier step: consume the low bit of mb, double ma.
  always_comb begin
    madd = mprod + {1'b0, ma};
    ma_n = ma; mb_n = mb; mprod_n = mprod; movf_n = movf;
    mdone = 1'b0;
    if (mb == '0 || ma == '0) begin
      mdone = 1'b1;
    end else begin
      if (mb[0]) begin
        mprod_n = madd;
        if (madd[W] || madd[W-1:0] > mlim) movf_n = 1'b1;
      end
      mb_n = mb >> 1;
      if (mb_n != '0 && ma[W-1]) movf_n = 1'b1;
      ma_n = ma << 1;
      if (movf_n) mdone = 1'b1;
    end
    mres = mneg ? (~mprod_n[W-1:0] + 1'b1) : mprod_n[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit <= U_IDLE;
      err <= cifa_pkg::ST_OK;
      cnt <= '0;
      rel <= 1'b1;
      op <= 4'd0;
      acc <= '0;
      prev <= '0;
    end else begin
      if (cmd.open) begin
        op <= command;
        acc <= operand;
        prev <= operand;
        cnt <= 2'd1;
        rel <= 1'b1;
        err <= (command > cifa_pkg::OpLastValid) ? cifa_pkg::ST_COUNT : cifa_pkg::ST_OK;
      end
      if (cmd.fold) begin
        if (cnt < 2'(cifa_pkg::GroupPair)) cnt <= cnt + 2'd1;
        if (err == cifa_pkg::ST_OK) begin
          prev <= operand;
          priority case (op)
            cifa_pkg::OP_ADD: begin
              if (add_ovf) err <= cifa_pkg::ST_OVF;
              else acc <= add_r;
            end
            cifa_pkg::OP_SUB: begin
              if (sub_ovf) err <= cifa_pkg::ST_OVF;
              else acc <= sub_r;
            end
            cifa_pkg::OP_MUL: begin
              {ma, mb, mlim, mneg} <= mul_start(acc, operand);
              mprod <= '0;
              movf <= 1'b0;
              unit <= U_MUL;
            end
            cifa_pkg::OP_DIV, cifa_pkg::OP_MOD: begin
              if (operand == '0) err <= cifa_pkg::ST_DIVZ;
              else if (acc == SignBit && operand == {W{1'b1}}) err <= cifa_pkg::ST_OVF;
              else begin
                dq <= magf(acc);
                dr <= '0;
                dd <= magf(operand);
                dnegq <= acc[W-1] ^ operand[W-1];
                dnegr <= acc[W-1];
                dcnt <= CW'(W);
                unit <= U_DIV;
              end
            end
            cifa_pkg::OP_POW: begin
              if (operand[W-1]) err <= cifa_pkg::ST_NEGEXP;
              else begin
                pacc <= {{(W-1){1'b0}}, 1'b1};
                psq <= acc;
                pe <= operand;
                unit <= U_POW_S;
                pmul_sel <= 1'b0;
              end
            end
            cifa_pkg::OP_AND: acc <= W'(acc != '0 && operand != '0);
            cifa_pkg::OP_OR:  acc <= W'(acc != '0 || operand != '0);
            cifa_pkg::OP_GT, cifa_pkg::OP_GEQ, cifa_pkg::OP_LT, cifa_pkg::OP_LEQ: begin
              if (!relok) rel <= 1'b0;
            end
            default: err <= cifa_pkg::ST_COUNT;
          endcase
        end
      end
      unique case (unit)
        U_IDLE: ;
        U_MUL, U_POW_M: begin
          ma <= ma_n; mb <= mb_n; mprod <= mprod_n; movf <= movf_n;
          if (mdone) begin
            if (movf_n) begin
              err <= cifa_pkg::ST_OVF;
              unit <= U_IDLE;
            end else if (unit == U_MUL) begin
              acc <= mres;
              unit <= U_IDLE;
            end else begin
              if (pmul_sel) pacc <= mres;
              else psq <= mres;
              unit <= U_POW_S;
            end
          end
        end
        U_POW_S: begin
          // Sequence: if e odd multiply acc; shift; if bits remain square.
          if (pe == '0) begin
            acc <= pacc;
            unit <= U_IDLE;
          end else if (pe[0] && !pmul_sel) begin
            {ma, mb, mlim, mneg} <= mul_start(pacc, psq);
            mprod <= '0;
            movf <= 1'b0;
            pmul_sel <= 1'b1;
            unit <= U_POW_M;
          end else begin
            if (pe[W-1:1] != '0) begin
              {ma, mb, mlim, mneg} <= mul_start(psq, psq);
              mprod <= '0;
              movf <= 1'b0;
              unit <= U_POW_M;
            end
            pe <= pe >> 1;
            pmul_sel <= 1'b0;
          end
        end
        U_DIV: begin
          if (dcnt == '0) begin
            acc <= (op == cifa_pkg::OP_MOD) ? (dnegr ? (~dr + 1'b1) : dr)
                                            : (dnegq ? (~dq + 1'b1) : dq);
            unit <= U_IDLE;
          end else begin
            dr <= dge ? dsub[W-1:0] : drem_sh[W-1:0];
            dq <= {dq[W-2:0], dge};
            dcnt <= dcnt - 1'b1;
          end
        end
        default: unit <= U_IDLE;
      endcase
    end
  end

  assign stat.busy = (unit != U_IDLE);

  // Final word from the held group state.
  logic [W-1:0] fval;
  logic [2:0]   fst;
  always_comb begin
    fst = err;
    fval = '0;
    if (err == cifa_pkg::ST_OK) begin
      if (cnt < 2'(cifa_pkg::GroupPair)) begin
        priority case (op)
          cifa_pkg::OP_ADD: fval = acc;
          cifa_pkg::OP_SUB: begin
            if (acc == SignBit) fst = cifa_pkg::ST_OVF;
            else fval = ~acc + 1'b1;
          end
          cifa_pkg::OP_NOT: fval = W'(acc == '0);
          default: fst = cifa_pkg::ST_COUNT;
        endcase
      end else if (op >= cifa_pkg::OP_GT && op <= cifa_pkg::OP_LEQ) begin
        fval = W'(rel);
      end else begin
        fval = acc;
      end
    end
    if (fst != cifa_pkg::ST_OK) fval = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      value <= 32'(fval);
      status <= fst;
    end
  end
endmodule

/* rtl/cifa_ctrl.sv */
// Controller: handshakes the channels and sequences the datapath.
module cifa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output cifa_pkg::cmd_t  cmd,
  input  cifa_pkg::stat_t stat
);
  typedef enum logic [1:0] {S_FIRST, S_NEXT, S_WAIT, S_FIN} state_t;
  state_t state;
  logic   last_held;

  assign in_ready = (state == S_FIRST || state == S_NEXT);

  always_comb begin
    cmd.open = in_valid && in_ready && state == S_FIRST;
    cmd.fold = in_valid && in_ready && state == S_NEXT;
    cmd.finish = (state == S_FIN) && !stat.busy && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FIRST;
      out_valid <= 1'b0;
      last_held <= 1'b0;
    end else begin
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_FIRST: if (cmd.open) state <= in_last ? S_FIN : S_NEXT;
        S_NEXT: if (cmd.fold) begin
          last_held <= in_last;
          state <= S_WAIT;
        end
        S_WAIT: if (!stat.busy) state <= last_held ? S_FIN : S_NEXT;
        S_FIN: if (cmd.finish) state <= S_FIRST;
        default: state <= S_FIRST;
      endcase
    end
  end
endmodule

/* rtl/checked_integer_fold_alu.sv */
// Top level: checked signed integer fold ALU.
// Usage:
//   Operand words arrive on in_ch (command, operand, last_operand). The first
//   word of a group latches the operation; each later word is folded into the
//   accumulator. The word marked last_operand produces one result word on
//   out_ch (value, status).
// Timing:
//   Words are taken one at a time; the step length sets the gap. Add, sub,
//   logic and relations pass through a fold state and a wait state per word.
//   Multiply is shift-add, one bit a cycle, stopping once the remaining bits
//   are zero or on overflow; div and mod use a restoring divider; pow runs
//   the same multiplier once or twice per exponent bit plus a control state.
//   The result word is registered from S_FIN, entered after the opening word
//   of a one-word group or once the step of the last folded word ends.
// Reset:
//   rst clears the controller, closes any open group and drops a pending
//   result word.
// Stall:
//   A result word is held until out_ch.ready; the next group may open and fold
//   while it waits, but input ready drops at its end until the word is taken.
module checked_integer_fold_alu #(
  parameter int DATA_WIDTH = cifa_pkg::DataWidth
) (
  input logic clk,
  input logic rst,
  cifa_in_if.sink    in_ch,
  cifa_out_if.source out_ch
);
  cifa_pkg::cmd_t  cmd;
  cifa_pkg::stat_t stat;

  cifa_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_last(in_ch.last_operand), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .stat
  );

  cifa_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk, .rst, .cmd,
    .command(in_ch.command), .operand(in_ch.operand),
    .stat, .value(out_ch.value), .status(out_ch.status)
  );
endmodule

/* test/testbench.sv */
// Testbench: directed and random operand groups checked against a fold predictor.
module testbench;

  localparam logic [3:0] CmdUnknownLo = 4'd13;
  localparam logic [3:0] CmdUnknownHi = 4'd15;
  localparam logic [31:0] IntMin = 32'h8000_0000;
  localparam logic [31:0] IntMax = 32'h7fff_ffff;
  localparam int CycleLimit = 5_000_000;
  localparam int HoldOffCycles = 600;
  localparam int SettleCycles = 120;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } fold_result_t;

  // One directed row: the word itself, plus a typed expectation where obvious.
  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] operand;
    logic               last_operand;
    logic               typed;
    logic signed [31:0] value;
    logic [2:0]         status;
  } word_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cifa_in_if  in_ch ();
  cifa_out_if out_ch ();

  checked_integer_fold_alu DUT (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: a private copy of the fold registers.
  logic [31:0] acc_q;
  logic [31:0] prev_q;
  logic [3:0]  op_q;
  int          count_q;
  logic        holds_q;
  logic [2:0]  err_q;
  logic        open_q;

  fold_result_t expected_results[$];
  int  mismatches;
  int  send_idle;
  int  recv_idle;
  bit  hold_req;
  int  hold_left;
  int  cycles = 0;

  // Checked arithmetic on 32-bit two's complement; set e on overflow or a zero divisor.
  function automatic logic [31:0] add_chk(input logic [31:0] a, b, inout logic [2:0] e);
    longint s;
    s = longint'($signed(a)) + longint'($signed(b));
    if (s > 64'sd2147483647 || s < -64'sd2147483648) e = cifa_pkg::ST_OVF;
    return s[31:0];
  endfunction

  function automatic logic [31:0] sub_chk(input logic [31:0] a, b, inout logic [2:0] e);
    longint s;
    s = longint'($signed(a)) - longint'($signed(b));
    if (s > 64'sd2147483647 || s < -64'sd2147483648) e = cifa_pkg::ST_OVF;
    return s[31:0];
  endfunction

  function automatic logic [31:0] mul_chk(input logic [31:0] a, b, inout logic [2:0] e);
    longint p;
    p = longint'($signed(a)) * longint'($signed(b));
    if (p > 64'sd2147483647 || p < -64'sd2147483648) begin
      e = cifa_pkg::ST_OVF;
      return '0;
    end
    return p[31:0];
  endfunction

  function automatic logic [31:0] divmod_chk(input logic [31:0] a, b, input bit rem,
                                             inout logic [2:0] e);
    int sa;
    int sb;
    sa = a;
    sb = b;
    if (b == '0) begin
      e = cifa_pkg::ST_DIVZ;
      return '0;
    end
    if (a == IntMin && b == 32'hffff_ffff) begin
      e = cifa_pkg::ST_OVF;
      return '0;
    end
    return rem ? sa % sb : sa / sb;
  endfunction

  // Square-and-multiply; square only while exponent bits remain.
  function automatic logic [31:0] pow_chk(input logic [31:0] base, ex, inout logic [2:0] e);
    logic [31:0] r;
    logic [31:0] sq;
    logic [31:0] rest;
    r = 32'd1;
    sq = base;
    rest = ex;
    if (ex[31]) begin
      e = cifa_pkg::ST_NEGEXP;
      return '0;
    end
    while (rest != 0) begin
      if (rest[0]) begin
        r = mul_chk(r, sq, e);
        if (e != cifa_pkg::ST_OK) return '0;
      end
      rest = rest >> 1;
      if (rest != 0) begin
        sq = mul_chk(sq, sq, e);
        if (e != cifa_pkg::ST_OK) return '0;
      end
    end
    return r;
  endfunction

  function automatic bit relation_ok(input logic [3:0] op, input logic [31:0] a, b);
    case (op)
      cifa_pkg::OP_GT:  return $signed(a) > $signed(b);
      cifa_pkg::OP_GEQ: return $signed(a) >= $signed(b);
      cifa_pkg::OP_LT:  return $signed(a) < $signed(b);
      default:          return $signed(a) <= $signed(b);
    endcase
  endfunction

  task automatic reset_fold();
    acc_q = '0;
    prev_q = '0;
    op_q = cifa_pkg::OP_ADD;
    count_q = 0;
    holds_q = 1'b1;
    err_q = cifa_pkg::ST_OK;
    open_q = 1'b0;
  endtask

  // Advance the predictor by one accepted word; flag a result on the last word.
  task automatic fold_word(input logic [3:0] cmd, input logic [31:0] y, input logic last,
                           output bit emits, output fold_result_t res);
    logic [2:0]  e;
    logic [31:0] r;
    emits = 1'b0;
    res = '0;
    if (!open_q) begin
      op_q = cmd;
      acc_q = y;
      prev_q = y;
      count_q = 1;
      holds_q = 1'b1;
      err_q = (cmd > cifa_pkg::OpLastValid) ? cifa_pkg::ST_COUNT : cifa_pkg::ST_OK;
      open_q = 1'b1;
    end else begin
      if (count_q < cifa_pkg::GroupPair) count_q++;
      if (err_q == cifa_pkg::ST_OK) begin
        e = cifa_pkg::ST_OK;
        r = acc_q;
        case (op_q)
          cifa_pkg::OP_ADD: r = add_chk(acc_q, y, e);
          cifa_pkg::OP_SUB: r = sub_chk(acc_q, y, e);
          cifa_pkg::OP_MUL: r = mul_chk(acc_q, y, e);
          cifa_pkg::OP_DIV: r = divmod_chk(acc_q, y, 1'b0, e);
          cifa_pkg::OP_MOD: r = divmod_chk(acc_q, y, 1'b1, e);
          cifa_pkg::OP_POW: r = pow_chk(acc_q, y, e);
          cifa_pkg::OP_AND: r = (acc_q != 0 && y != 0) ? 32'd1 : 32'd0;
          cifa_pkg::OP_OR:  r = (acc_q != 0 || y != 0) ? 32'd1 : 32'd0;
          cifa_pkg::OP_GT, cifa_pkg::OP_GEQ, cifa_pkg::OP_LT, cifa_pkg::OP_LEQ: begin
            if (!relation_ok(op_q, prev_q, y)) holds_q = 1'b0;
          end
          default: e = cifa_pkg::ST_COUNT;
        endcase
        if (e != cifa_pkg::ST_OK) err_q = e;
        else acc_q = r;
        prev_q = y;
      end
    end
    if (last) begin
      e = err_q;
      r = '0;
      if (e == cifa_pkg::ST_OK) begin
        if (count_q < cifa_pkg::GroupPair) begin
          case (op_q)
            cifa_pkg::OP_ADD: r = acc_q;
            cifa_pkg::OP_SUB: r = sub_chk(32'd0, acc_q, e);
            cifa_pkg::OP_NOT: r = (acc_q == 0) ? 32'd1 : 32'd0;
            default:          e = cifa_pkg::ST_COUNT;
          endcase
        end else if (op_q >= cifa_pkg::OP_GT && op_q <= cifa_pkg::OP_LEQ) begin
          r = holds_q ? 32'd1 : 32'd0;
        end else begin
          r = acc_q;
        end
      end
      if (e != cifa_pkg::ST_OK) r = '0;
      res.value = r;
      res.status = e;
      emits = 1'b1;
      open_q = 1'b0;
    end
  endtask

  // Offer one word, log what it should cause, then hold it until the handshake.
  // Entered and left at a rising edge; ready is read at the falling edge.
  task automatic send_word(input logic [3:0] cmd, input logic [31:0] y, input logic last,
                           input bit typed, input fold_result_t typed_res);
    bit           taken;
    bit           emits;
    fold_result_t res;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.operand      <= y;
    in_ch.last_operand <= last;
    fold_word(cmd, y, last, emits, res);
    if (emits) expected_results.push_back(typed ? typed_res : res);
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Drop valid and wait until every result is back, then let the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0:       return IntMin;
      1:       return IntMax;
      2:       return 32'd0;
      3:       return $urandom_range(1) ? 32'd1 : 32'hffff_ffff;
      4, 5, 6: return $urandom_range(40) - 20;
      7:       return $urandom_range(140000) - 70000;
      default: return $urandom;
    endcase
  endfunction

  // Random group with the command on the first word and random bits after it.
  task automatic send_random_groups(input int words);
    logic [3:0]  cmd;
    logic [31:0] y;
    int          len;
    int          sent;
    sent = 0;
    while (sent < words) begin
      cmd = ($urandom_range(29) == 0) ? 4'($urandom_range(CmdUnknownHi, CmdUnknownLo))
                                      : 4'($urandom_range(cifa_pkg::OpLastValid));
      len = ($urandom_range(7) == 0) ? $urandom_range(8, 1) : $urandom_range(4, 1);
      if (cmd == cifa_pkg::OP_NOT && $urandom_range(3) != 0) len = 1;
      for (int k = 0; k < len; k++) begin
        y = pick_operand();
        if (cmd == cifa_pkg::OP_POW) begin
          if (k == 0) y = ($urandom_range(3) == 0) ? pick_operand() : $urandom_range(12) - 6;
          else if ($urandom_range(5) == 0) y = $urandom;
          else y = $urandom_range(35);
        end
        send_word((k == 0) ? cmd : 4'($urandom), y, logic'(k == len - 1), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Receiver: random back-pressure, or a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_req) begin
        hold_left = HoldOffCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Result check: both sides are stable at the falling edge, so a word seen
  // there with valid and ready high is taken at the next rising edge.
  always @(negedge clk) begin
    fold_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: value %0d status %0d",
                   out_ch.value, out_ch.status);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.value !== want.value || out_ch.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected value %0d status %0d, got value %0d status %0d",
                     want.value, want.status, out_ch.value, out_ch.status);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** checked_integer_fold_alu: FAILED **");
      $finish;
    end
  end

  // Directed words: extremes, the operations other than GEQ and LT, and the corner cases.
  word_row_t directed[] = '{
    '{cifa_pkg::OP_ADD, 32'sd5,  1'b1, 1'b1, 32'sd5, cifa_pkg::ST_OK},   // identity
    '{cifa_pkg::OP_SUB, IntMin,  1'b1, 1'b1, 32'sd0, cifa_pkg::ST_OVF},  // negate min
    '{cifa_pkg::OP_NOT, 32'sd0,  1'b1, 1'b1, 32'sd1, cifa_pkg::ST_OK},
    '{cifa_pkg::OP_NOT, 32'sd7,  1'b1, 1'b1, 32'sd0, cifa_pkg::ST_OK},
    '{cifa_pkg::OP_MUL, 32'sd3,  1'b1, 1'b1, 32'sd0, cifa_pkg::ST_COUNT}, // too few words
    '{CmdUnknownHi, 32'sd1, 1'b1, 1'b1, 32'sd0, cifa_pkg::ST_COUNT},
    '{cifa_pkg::OP_ADD, IntMax,  1'b0, 1'b0, 32'sd0, cifa_pkg::ST_OK},
    '{cifa_pkg::OP_ADD, 32'sd1,  1'b1, 1'b1, 32'sd0, cifa_pkg::ST_OVF},
    '{cifa_pkg::OP_DIV, IntMin,  1'b0, 1'b0, 32'sd0, cifa_pkg::ST_OK},
    '{cifa_pkg::OP_DIV, -32'sd1, 1'b1, 1'b1, 32'sd0, cifa_pkg::ST_OVF},
    '{cifa_pkg::OP_MOD, 32'sd7,  1'b0, 1'b0, 32'sd0, cifa_pkg::ST_OK},
    '{cifa_pkg::OP_MOD, 32'sd0,  1'b1, 1'b1, 32'sd0, cifa_pkg::ST_DIVZ},
    '{cifa_pkg::OP_POW, 32'sd2,  1'b0, 1'b0, 32'sd0, cifa_pkg::ST_OK},
    '{cifa_pkg::OP_POW, -32'sd1, 1'b1, 1'b1, 32'sd0, cifa_pkg::ST_NEGEXP},
    '{cifa_pkg::OP_POW, -32'sd2, 1'b0, 1'b0, 32'sd0, cifa_pkg::ST_OK},   // reaches the min
    '{cifa_pkg::OP_POW, 32'sd31, 1'b1, 1'b0, 32'sd0, cifa_pkg::ST_OK},
    '{cifa_pkg::OP_NOT, 32'sd1,  1'b0, 1'b0, 32'sd0, cifa_pkg::ST_OK},
    '{cifa_pkg::OP_NOT, 32'sd2,  1'b1, 1'b1, 32'sd0, cifa_pkg::ST_COUNT}, // one word only
    '{cifa_pkg::OP_LEQ, 32'sd3,  1'b0, 1'b0, 32'sd0, cifa_pkg::ST_OK},
    '{cifa_pkg::OP_LEQ, 32'sd3,  1'b0, 1'b0, 32'sd0, cifa_pkg::ST_OK},
    '{cifa_pkg::OP_LEQ, 32'sd4,  1'b1, 1'b1, 32'sd1, cifa_pkg::ST_OK},
    '{cifa_pkg::OP_GT,  IntMax,  1'b0, 1'b0, 32'sd0, cifa_pkg::ST_OK},
    '{cifa_pkg::OP_GT,  IntMin,  1'b1, 1'b1, 32'sd1, cifa_pkg::ST_OK},
    '{cifa_pkg::OP_AND, 32'sd5,  1'b0, 1'b0, 32'sd0, cifa_pkg::ST_OK},
    '{cifa_pkg::OP_AND, 32'sd0,  1'b1, 1'b1, 32'sd0, cifa_pkg::ST_OK},
    '{cifa_pkg::OP_OR,  32'sd0,  1'b0, 1'b0, 32'sd0, cifa_pkg::ST_OK},
    '{cifa_pkg::OP_OR,  -32'sd9, 1'b1, 1'b1, 32'sd1, cifa_pkg::ST_OK}
  };

  initial begin
    fold_result_t typed_res;
    in_ch.valid = 1'b0;
    in_ch.command = cifa_pkg::OP_ADD;
    in_ch.operand = '0;
    in_ch.last_operand = 1'b0;
    mismatches = 0;
    hold_req = 1'b0;
    send_idle = 38;
    recv_idle = 58;
    reset_fold();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      typed_res.value = directed[i].value;
      typed_res.status = directed[i].status;
      send_word(directed[i].command, directed[i].operand, directed[i].last_operand,
                directed[i].typed, typed_res);
    end

    send_random_groups(220);
    // Stall the receiver for a long stretch while words keep coming.
    hold_req = 1'b1;
    send_random_groups(220);
    // Pause the sender until every result is home.
    drain();

    send_idle = 58;
    recv_idle = 38;
    send_random_groups(490);
    drain();

    send_idle = 0;
    recv_idle = 0;
    send_random_groups(490);
    drain();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("** checked_integer_fold_alu: PASSED **");
    end else begin
      $display("** checked_integer_fold_alu: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/cifa_pkg.sv
rtl/cifa_if.sv
rtl/cifa_datapath.sv
rtl/cifa_ctrl.sv
rtl/checked_integer_fold_alu.sv
test/testbench.sv
